// ----- src/touch_keypad_passcode_lock_defines.svh -----
// Assertion helpers shared by the keypad lock RTL.
`ifndef TOUCH_KEYPAD_PASSCODE_LOCK_DEFINES_SVH
`define TOUCH_KEYPAD_PASSCODE_LOCK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TKPL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("keypad lock check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TKPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("keypad lock check failed");

`endif

// ----- src/tkpl_pkg.sv -----
package tkpl_pkg;

    localparam int CODE_DIGITS = 6;
    localparam int KEY_COUNT   = 12;

    localparam int CNT_W = $clog2(CODE_DIGITS + 1);
    localparam int PASS_W = 24;
    localparam int PASS_EXT_W = 32;

    typedef logic [9:0] t_coord;
    typedef logic [3:0] t_key;
    typedef logic [3:0] t_digit;
    typedef logic [CNT_W-1:0] t_count;

    localparam t_key KEY_CONFIRM   = 4'd10;
    localparam t_key KEY_BACKSPACE = 4'd11;
    localparam t_key KEY_NONE      = 4'd12;
    localparam t_key KEY_LAST_DIGIT = 4'd9;

    localparam logic [PASS_W-1:0] PASSCODE_RESET = 24'h123456;

    // Key rectangles, bounds inclusive: digits 0-9, confirm, backspace.
    localparam t_coord KEY_X_LO [KEY_COUNT] = '{
        10'd195, 10'd90, 10'd195, 10'd300, 10'd90, 10'd195,
        10'd300, 10'd90, 10'd195, 10'd300, 10'd90, 10'd300};
    localparam t_coord KEY_X_HI [KEY_COUNT] = '{
        10'd275, 10'd170, 10'd275, 10'd380, 10'd170, 10'd275,
        10'd380, 10'd170, 10'd275, 10'd380, 10'd170, 10'd380};
    localparam t_coord KEY_Y_LO [KEY_COUNT] = '{
        10'd340, 10'd240, 10'd240, 10'd240, 10'd140, 10'd140,
        10'd140, 10'd45, 10'd45, 10'd45, 10'd340, 10'd340};
    localparam t_coord KEY_Y_HI [KEY_COUNT] = '{
        10'd420, 10'd320, 10'd320, 10'd320, 10'd220, 10'd220,
        10'd220, 10'd125, 10'd125, 10'd125, 10'd420, 10'd420};

    // Hit test result handed from the key decoder to the control logic.
    typedef struct packed {
        t_key   key;
        logic   hit;
        t_coord x_lo;
        t_coord y_lo;
    } t_hit;

endpackage

// ----- src/tkpl_hit_test.sv -----
module tkpl_hit_test (
    input  tkpl_pkg::t_coord i_x,
    input  tkpl_pkg::t_coord i_y,
    output tkpl_pkg::t_hit   o_hit
);
    import tkpl_pkg::*;

    logic [KEY_COUNT-1:0] inside_box;

    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            inside_box[k] = (i_x >= KEY_X_LO[k]) && (i_x <= KEY_X_HI[k]) &&
                            (i_y >= KEY_Y_LO[k]) && (i_y <= KEY_Y_HI[k]);
        end
    end

    // Walk down so the lowest matching key wins.
    always_comb begin
        o_hit.key  = KEY_NONE;
        o_hit.hit  = 1'b0;
        o_hit.x_lo = '0;
        o_hit.y_lo = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (inside_box[k]) begin
                o_hit.key  = t_key'(k);
                o_hit.hit  = 1'b1;
                o_hit.x_lo = KEY_X_LO[k];
                o_hit.y_lo = KEY_Y_LO[k];
            end
        end
    end

endmodule

// ----- src/touch_keypad_passcode_lock.sv -----
// Touch keypad passcode lock. Each input transfer is one touch event (x, y and
// a kind: click or press); each event yields exactly one result transfer. The
// point is hit-tested against twelve fixed key rectangles (digits 0-9, confirm,
// backspace; first match wins). A click appends a digit while fewer than six
// are held, removes the last digit on backspace, and on confirm with a full
// entry compares against the passcode register: a match sets the sticky
// unlocked flag, a mismatch clears the entry and flags the result as rejected.
// Every click re-arms press feedback; the first press after that reports the
// top-left corner of the touched key. An event passes from the input register
// to the result register, and one event is accepted every cycle while the
// result sink does not stall; the state update sits between those two registers.
// The passcode register is written through the configuration channel,
// which is always ready and must only be used while no event is in flight.
`include "touch_keypad_passcode_lock_defines.svh"

module touch_keypad_passcode_lock (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // touch_x[9:0], touch_y[19:10], zero pad
    input  logic [0:0]  s_axis_tuser,   // operation[0]: 0 click, 1 press
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // key_code[3:0], entered_count[6:4], unlocked[7], rejected[8],
    // feedback_valid[9], feedback_x[19:10], feedback_y[29:20], zero pad
    output logic [31:0] m_axis_tdata,
    // passcode write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tkpl_pkg::PASS_W-1:0] i_cfg_data
);
    import tkpl_pkg::*;

    // Input register
    logic   r_in_valid;
    logic   r_in_op;
    t_coord r_in_x;
    t_coord r_in_y;

    // Lock state
    logic [PASS_W-1:0] r_passcode;
    t_digit r_digits [CODE_DIGITS];
    t_digit n_digits [CODE_DIGITS];
    t_count r_count;
    t_count n_count;
    logic   r_unlocked;
    logic   n_unlocked;
    logic   r_armed;
    logic   n_armed;

    // Result register
    logic   r_out_valid;
    t_key   r_out_key;
    logic [2:0] r_out_count;
    logic   r_out_unlocked;
    logic   r_out_rejected;
    logic   r_out_fb_valid;
    t_coord r_out_fb_x;
    t_coord r_out_fb_y;

    logic   n_rejected;
    logic   n_fb_valid;
    t_coord n_fb_x;
    t_coord n_fb_y;

    t_hit   hit;
    logic   advance;
    logic   process;
    logic   code_match;
    logic [PASS_EXT_W-1:0] code_ext;
    logic [7:0] count_ext;

    // Result slot free, or its transfer completes this cycle.
    assign advance       = !r_out_valid || m_axis_tready;
    // Event in the input register moves into the result register.
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    // Passcode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passcode <= PASSCODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_passcode <= i_cfg_data;
        end
    end

    // Input register: refill whenever the held event moves on or the slot is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op <= s_axis_tuser[0];
            r_in_x  <= s_axis_tdata[9:0];
            r_in_y  <= s_axis_tdata[19:10];
        end
    end

    tkpl_hit_test u_hit_test (
        .i_x   (r_in_x),
        .i_y   (r_in_y),
        .o_hit (hit)
    );

    // Compare the held digits with the passcode, first digit in the top used
    // nibble; nibbles above the register width read as zero.
    assign code_ext = PASS_EXT_W'(r_passcode);

    always_comb begin
        code_match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (r_digits[i] != code_ext[(CODE_DIGITS - 1 - i) * 4 +: 4]) begin
                code_match = 1'b0;
            end
        end
    end

    // Next state and result fields for the event in the input register.
    always_comb begin
        n_digits   = r_digits;
        n_count    = r_count;
        n_unlocked = r_unlocked;
        n_armed    = r_armed;
        n_rejected = 1'b0;
        n_fb_valid = 1'b0;
        n_fb_x     = '0;
        n_fb_y     = '0;
        if (!r_in_op) begin
            // Click: edit or confirm the entry, then re-arm feedback.
            if (hit.key <= KEY_LAST_DIGIT) begin
                // Append, unless the entry is already full.
                if (r_count < t_count'(CODE_DIGITS)) begin
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (t_count'(i) == r_count) begin
                            n_digits[i] = hit.key;
                        end
                    end
                    n_count = r_count + t_count'(1);
                end
            end else if (hit.key == KEY_CONFIRM) begin
                // Confirm acts only on a full entry.
                if (r_count == t_count'(CODE_DIGITS)) begin
                    if (code_match) begin
                        n_unlocked = 1'b1;
                    end else begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            n_digits[i] = '0;
                        end
                        n_count    = '0;
                        n_rejected = 1'b1;
                    end
                end
            end else if (hit.key == KEY_BACKSPACE) begin
                // Drop the last digit; nothing to drop on an empty entry.
                if (r_count != '0) begin
                    n_count = r_count - t_count'(1);
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (t_count'(i) == n_count) begin
                            n_digits[i] = '0;
                        end
                    end
                end
            end
            n_armed = 1'b1;
        end else if (r_armed) begin
            // Press: report the key corner once, then disarm even on a miss.
            if (hit.hit) begin
                n_fb_valid = 1'b1;
                n_fb_x     = hit.x_lo;
                n_fb_y     = hit.y_lo;
            end
            n_armed = 1'b0;
        end
    end

    assign count_ext = 8'(n_count);

    // State registers advance only when the event commits to the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_unlocked <= 1'b0;
            r_armed    <= 1'b1;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                r_digits[i] <= '0;
            end
        end else if (process) begin
            r_count    <= n_count;
            r_unlocked <= n_unlocked;
            r_armed    <= n_armed;
            r_digits   <= n_digits;
        end
    end

    // Result register: hold while the sink stalls, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_key      <= hit.key;
            r_out_count    <= count_ext[2:0];
            r_out_unlocked <= n_unlocked;
            r_out_rejected <= n_rejected;
            r_out_fb_valid <= n_fb_valid;
            r_out_fb_x     <= n_fb_x;
            r_out_fb_y     <= n_fb_y;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_fb_y, r_out_fb_x, r_out_fb_valid,
                            r_out_rejected, r_out_unlocked, r_out_count, r_out_key};

    // The entry never grows past the code length.
    `TKPL_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= t_count'(CODE_DIGITS))
    // Unlock is sticky.
    `TKPL_ASSERT_NEXT(a_unlock_sticky, r_unlocked, r_unlocked)
    // A rejection always leaves an empty entry and no feedback.
    `TKPL_ASSERT_IMPL(a_reject_clears, r_out_valid && r_out_rejected,
                      r_out_count == 3'd0 && !r_out_fb_valid)
    // Feedback only for a real key, and it disarms until the next click.
    `TKPL_ASSERT_IMPL(a_fb_key, r_out_valid && r_out_fb_valid,
                      r_out_key != KEY_NONE)
    `TKPL_ASSERT_NEXT(a_fb_disarms, process && n_fb_valid, !r_armed)

endmodule

// ----- sim/touch_keypad_passcode_lock_test.sv -----
module touch_keypad_passcode_lock_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tkpl_pkg::*;

    // Event kinds carried on s_axis_tuser.
    localparam bit OP_CLICK = 1'b0;
    localparam bit OP_PRESS = 1'b1;

    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT = 1000;
    // Result count at which the receiver starts its one long hold-off.
    localparam int LONG_HOLD_AT = 500;
    localparam int LONG_HOLD_CYCLES = 80;

    // One expected result, field by field.
    typedef struct packed {
        t_key   key;
        t_count count;
        logic   unlocked;
        logic   rejected;
        logic   fb_valid;
        t_coord fb_x;
        t_coord fb_y;
    } t_lock_result;

    // Tracks the lock state, predicts the result of every accepted touch and
    // checks each result transfer against the oldest prediction.
    class t_lock_tracker;
        logic [PASS_W-1:0] code;
        t_digit            digits [CODE_DIGITS];
        int                count;
        bit                unlocked;
        bit                armed;
        t_lock_result      pending_results [$];
        int                mismatches;

        function new();
            code = PASSCODE_RESET;
            foreach (digits[i]) digits[i] = '0;
            count = 0;
            unlocked = 1'b0;
            armed = 1'b1;
            mismatches = 0;
        endfunction

        // Hit test: first rectangle that holds the point, bounds inclusive.
        function t_key key_under(t_coord x, t_coord y);
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (x >= KEY_X_LO[k] && x <= KEY_X_HI[k] &&
                    y >= KEY_Y_LO[k] && y <= KEY_Y_HI[k])
                    return t_key'(k);
            end
            return KEY_NONE;
        endfunction

        // First entered digit is compared with the top used nibble.
        function bit entry_matches();
            int pos;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                pos = (CODE_DIGITS - 1 - i) * 4;
                if (t_digit'(code >> pos) != digits[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_touch(bit op, t_coord x, t_coord y);
            t_lock_result r;
            t_key         k;
            k = key_under(x, y);
            r = '0;
            r.key = k;
            if (op == OP_CLICK) begin
                if (k <= KEY_LAST_DIGIT) begin
                    // digits past a full entry are dropped
                    if (count < CODE_DIGITS) begin
                        digits[count] = k;
                        count++;
                    end
                end else if (k == KEY_CONFIRM) begin
                    // a short entry ignores confirm
                    if (count == CODE_DIGITS) begin
                        if (entry_matches()) begin
                            unlocked = 1'b1;
                        end else begin
                            foreach (digits[i]) digits[i] = '0;
                            count = 0;
                            r.rejected = 1'b1;
                        end
                    end
                end else if (k == KEY_BACKSPACE) begin
                    if (count > 0) begin
                        count--;
                        digits[count] = '0;
                    end
                end
                armed = 1'b1;
            end else if (armed) begin
                // a press on no key still uses up the arming
                if (k != KEY_NONE) begin
                    r.fb_valid = 1'b1;
                    r.fb_x = KEY_X_LO[k];
                    r.fb_y = KEY_Y_LO[k];
                end
                armed = 1'b0;
            end
            r.count = t_count'(count);
            r.unlocked = unlocked;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(logic [31:0] d);
            t_lock_result w;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result 0x%08h with no touch pending", d));
                return;
            end
            w = pending_results.pop_front();
            if (d[3:0] != w.key)
                report_mismatch($sformatf("key_code %0d, want %0d", d[3:0], w.key));
            if (d[6:4] != w.count)
                report_mismatch($sformatf("entered_count %0d, want %0d", d[6:4], w.count));
            if (d[7] != w.unlocked)
                report_mismatch($sformatf("unlocked %0b, want %0b", d[7], w.unlocked));
            if (d[8] != w.rejected)
                report_mismatch($sformatf("rejected %0b, want %0b", d[8], w.rejected));
            if (d[9] != w.fb_valid)
                report_mismatch($sformatf("feedback_valid %0b, want %0b", d[9], w.fb_valid));
            if (d[19:10] != w.fb_x)
                report_mismatch($sformatf("feedback_x %0d, want %0d", d[19:10], w.fb_x));
            if (d[29:20] != w.fb_y)
                report_mismatch($sformatf("feedback_y %0d, want %0d", d[29:20], w.fb_y));
            if (d[31:30] != 2'b00)
                report_mismatch($sformatf("pad bits %0b, want 0", d[31:30]));
        endtask
    endclass

    // All inputs of the block start at known values.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PASS_W-1:0] i_cfg_data = '0;

    t_lock_tracker tracker = new();

    bit idle_en = 1'b1;     // random bursts of idling on both sides
    int touches_sent = 0;   // accepted input transfers
    int results_seen = 0;   // accepted result transfers
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    touch_keypad_passcode_lock dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: drive tready at the falling edge. Hold off once for a long
    // stretch so the block fills and stalls its input; otherwise stall in
    // short random bursts while idling is enabled.
    always @(negedge i_clk) begin
        bit rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_axis_tready <= rdy;
    end

    // Check every result transfer at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata);
            results_seen++;
        end
    end

    // Watchdog: count cycles in which nothing transfers on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one touch event; hold it until the transfer, then log it.
    // A random gap may come first while idling is enabled.
    task automatic send_event(bit op, t_coord x, t_coord y);
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0000, y, x};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_touch(op, x, y);
        touches_sent++;
    endtask

    // Pick a point on key k: often a corner or edge, else anywhere inside.
    // For no key, pick a near miss beside a rectangle or a random point.
    task automatic pick_point(int k, output t_coord x, output t_coord y);
        int b;
        if (k == KEY_NONE) begin
            do begin
                b = $urandom_range(0, KEY_COUNT - 1);
                if ($urandom_range(0, 1) == 0) begin
                    x = $urandom_range(0, 1) ? t_coord'(KEY_X_LO[b] - 1)
                                             : t_coord'(KEY_X_HI[b] + 1);
                    y = t_coord'($urandom_range(KEY_Y_LO[b] - 1, KEY_Y_HI[b] + 1));
                end else begin
                    x = t_coord'($urandom_range(0, 1023));
                    y = t_coord'($urandom_range(0, 1023));
                end
            end while (tracker.key_under(x, y) != KEY_NONE);
        end else if ($urandom_range(0, 3) == 0) begin
            x = $urandom_range(0, 1) ? KEY_X_LO[k] : KEY_X_HI[k];
            y = $urandom_range(0, 1) ? KEY_Y_LO[k] : KEY_Y_HI[k];
        end else begin
            x = t_coord'($urandom_range(KEY_X_LO[k], KEY_X_HI[k]));
            y = t_coord'($urandom_range(KEY_Y_LO[k], KEY_Y_HI[k]));
        end
    endtask

    task automatic send_key(bit op, int k);
        t_coord x;
        t_coord y;
        pick_point(k, x, y);
        send_event(op, x, y);
    endtask

    // One passcode attempt with random content: clear leftovers, type digits
    // with the odd slip and press, maybe overflow, then confirm.
    task automatic entry_attempt(bit use_code);
        int     n;
        t_digit d;
        if ($urandom_range(0, 7) != 0)
            while (tracker.count > 0) send_key(OP_CLICK, KEY_BACKSPACE);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, CODE_DIGITS - 1) : CODE_DIGITS;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_key(OP_CLICK, $urandom_range(0, 9));
                send_key(OP_CLICK, KEY_BACKSPACE);
            end
            if ($urandom_range(0, 7) == 0)
                send_key(OP_PRESS, $urandom_range(0, KEY_NONE));
            d = use_code ? t_digit'(tracker.code >> ((CODE_DIGITS - 1 - i) * 4))
                         : t_digit'($urandom_range(0, 9));
            send_key(OP_CLICK, d);
        end
        if ($urandom_range(0, 7) == 0)
            send_key(OP_CLICK, $urandom_range(0, 9));
        send_key(OP_CLICK, KEY_CONFIRM);
        if ($urandom_range(0, 3) == 0)
            send_key(OP_PRESS, $urandom_range(0, KEY_NONE));
    endtask

    // Raw touches anywhere on the screen, either kind.
    task automatic noise_burst();
        repeat ($urandom_range(1, 5))
            send_event(bit'($urandom_range(0, 1)), t_coord'($urandom_range(0, 1023)),
                       t_coord'($urandom_range(0, 1023)));
    endtask

    // Drop tvalid and wait until every predicted result is in, plus some margin.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_passcode(logic [PASS_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.code = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit all_decimal(logic [PASS_W-1:0] value);
        for (int i = 0; i < PASS_W / 4; i++)
            if (value[i*4 +: 4] > 4'd9) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [PASS_W-1:0] random_decimal_code();
        logic [PASS_W-1:0] value;
        for (int i = 0; i < PASS_W / 4; i++)
            value[i*4 +: 4] = t_digit'($urandom_range(0, 9));
        return value;
    endfunction

    initial begin
        int                phase_end;
        logic [PASS_W-1:0] next_code;
        bit                use_code;

        // Hold reset, then release it at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset passcode.
        send_event(OP_PRESS, KEY_X_LO[5], KEY_Y_LO[5]);       // armed press, corner
        send_key(OP_PRESS, 5);                                 // disarmed press
        send_event(OP_CLICK, 10'd0, 10'd0);                    // click on no key re-arms
        send_event(OP_PRESS, 10'd1023, 10'd1023);              // armed press on no key
        send_key(OP_PRESS, 1);                                 // still disarmed
        send_key(OP_CLICK, KEY_BACKSPACE);                     // empty backspace
        send_key(OP_CLICK, KEY_CONFIRM);                       // short confirm
        send_event(OP_CLICK, KEY_X_HI[1], KEY_Y_HI[1]);
        send_event(OP_CLICK, KEY_X_LO[2], KEY_Y_HI[2]);
        send_event(OP_CLICK, KEY_X_HI[3], KEY_Y_LO[3]);
        send_key(OP_CLICK, KEY_BACKSPACE);
        send_key(OP_CLICK, KEY_CONFIRM);
        send_key(OP_CLICK, 3);
        send_key(OP_CLICK, 4);
        send_key(OP_CLICK, 5);
        send_key(OP_CLICK, 7);
        send_key(OP_CLICK, 9);                                 // full entry, dropped
        send_key(OP_PRESS, KEY_CONFIRM);                       // feedback on confirm key
        send_key(OP_CLICK, KEY_CONFIRM);                       // wrong full entry
        send_key(OP_PRESS, KEY_BACKSPACE);
        send_event(OP_CLICK, 10'd194, 10'd380);                // one pixel left of key 0
        send_event(OP_CLICK, 10'd276, 10'd421);                // one pixel off a corner
        send_key(OP_PRESS, 0);

        // Random part in phases, each under its own passcode. The right code
        // is only typed from phase four on, so the locked state gets a long run.
        for (int phase = 0; phase < 9; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: next_code = '0;
                    2: next_code = '1;
                    4: next_code = 24'h999999;
                    5: next_code = PASS_W'($urandom);
                    default: next_code = random_decimal_code();
                endcase
                write_passcode(next_code);
            end
            idle_en = (phase % 3 != 2) && (phase != 8);
            phase_end = (phase + 1) * 200;
            while (touches_sent < phase_end) begin
                use_code = (phase >= 4) && all_decimal(tracker.code) &&
                           ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 3) == 0)
                    noise_burst();
                else
                    entry_attempt(use_code);
            end
        end

        // Let the last results arrive and give the block a few more cycles.
        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
